// File: hdl/kvcr_pkg.sv
// Shared types and constants for the sliding-window row cache.
package kvcr_pkg;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned ROW_BITS    = 64;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned SINK_W  = 10;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND    = 3'd0,
    FN_WINDOW    = 3'd1,
    FN_OVERWRITE = 3'd2,
    FN_POP       = 3'd3,
    FN_CLEAR     = 3'd4,
    FN_READ      = 3'd5
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_BAD_IDX = 3'd2,
    ST_POP_OVR = 3'd3,
    ST_BAD_CFG = 3'd4
  } status_e;

  // Register index on the config port (paddr[2]).
  localparam logic REG_WINDOW_LIMIT = 1'b0;
  localparam logic REG_SINK_ROWS    = 1'b1;

  localparam logic [CNT_W-1:0]  WINDOW_LIMIT_RST = 11'd1024;
  localparam logic [SINK_W-1:0] SINK_ROWS_RST    = 10'd0;

  typedef struct packed {
    logic [CNT_W-1:0]  window_limit;
    logic [SINK_W-1:0] sink_rows;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ROW_BITS-1:0] wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } mem_req_t;

endpackage

// File: hdl/kvcr_ram.sv
// Single-port-write, single-port-read row memory with registered read data.
module kvcr_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/kvcr_cfg.sv
// APB register file: window limit and sink row count.
module kvcr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kvcr_pkg::APB_AW-1:0]   paddr,
  input  logic [kvcr_pkg::APB_DW-1:0]   pwdata,
  output logic [kvcr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output kvcr_pkg::cfg_t                cfg_o
);

  kvcr_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (paddr[2] == kvcr_pkg::REG_WINDOW_LIMIT) begin
        cfg_d.window_limit = pwdata[kvcr_pkg::CNT_W-1:0];
      end else begin
        cfg_d.sink_rows = pwdata[kvcr_pkg::SINK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_limit <= kvcr_pkg::WINDOW_LIMIT_RST;
      cfg_q.sink_rows    <= kvcr_pkg::SINK_ROWS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    if (paddr[2] == kvcr_pkg::REG_WINDOW_LIMIT) begin
      prdata = kvcr_pkg::APB_DW'(cfg_q.window_limit);
    end else begin
      prdata = kvcr_pkg::APB_DW'(cfg_q.sink_rows);
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/kvcr_ctrl.sv
// Operation decode, fill/ring counters, memory requests and result registers.
module kvcr_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [kvcr_pkg::FUNC_W-1:0]     func_i,
  input  logic [kvcr_pkg::DATA_W-1:0]     entry_data_i,
  input  logic [kvcr_pkg::IDX_W-1:0]      row_index_i,
  input  logic [kvcr_pkg::CNT_W-1:0]      pop_count_i,
  input  kvcr_pkg::cfg_t                  cfg_i,
  output kvcr_pkg::mem_req_t              mem_req_o,
  input  logic [kvcr_pkg::ROW_BITS-1:0]   mem_rdata_i,
  output logic                            done_o,
  output logic [kvcr_pkg::DATA_W-1:0]     read_data_o,
  output logic [kvcr_pkg::STAT_W-1:0]     status_o,
  output logic [kvcr_pkg::CNT_W-1:0]      rows_filled_o,
  output logic [kvcr_pkg::IDX_W-1:0]      written_slot_o
);

  localparam int unsigned CntW  = kvcr_pkg::CNT_W;
  localparam int unsigned AddrW = kvcr_pkg::ADDR_W;

  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] ring_q, ring_d;

  logic                          done_q;
  logic                          rd_ok_q, rd_ok_d;
  kvcr_pkg::status_e             status_q, status_d;
  logic [kvcr_pkg::IDX_W-1:0]    slot_q, slot_d;
  logic [CntW-1:0]               rows_q;

  logic            bad_cfg;
  logic            store_full;
  logic            idx_bad;
  logic [CntW:0]   fill_inc;
  logic [CntW-1:0] idx_ext;
  logic [CntW-1:0] sink_ext;
  logic [AddrW-1:0] waddr;

  assign sink_ext   = CntW'(cfg_i.sink_rows);
  assign idx_ext    = CntW'(row_index_i);
  assign bad_cfg    = (cfg_i.window_limit == '0)
                    || (32'(cfg_i.window_limit) > kvcr_pkg::STORE_DEPTH)
                    || (sink_ext >= cfg_i.window_limit);
  assign store_full = 32'(fill_q) >= kvcr_pkg::STORE_DEPTH;
  assign idx_bad    = (idx_ext >= fill_q)
                    || (32'(row_index_i) >= kvcr_pkg::STORE_DEPTH);
  assign fill_inc   = {1'b0, fill_q} + 1'b1;

  always_comb begin
    fill_d   = fill_q;
    ring_d   = ring_q;
    status_d = kvcr_pkg::ST_OK;
    slot_d   = '0;
    rd_ok_d  = 1'b0;
    mem_req_o.we    = 1'b0;
    waddr           = '0;
    mem_req_o.wdata = entry_data_i[kvcr_pkg::ROW_BITS-1:0];
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = row_index_i[AddrW-1:0];
    if (accept_i) begin
      case (kvcr_pkg::func_e'(func_i))
        kvcr_pkg::FN_APPEND: begin
          if (store_full) begin
            status_d = kvcr_pkg::ST_FULL;
          end else begin
            waddr        = fill_q[AddrW-1:0];
            mem_req_o.we = 1'b1;
            fill_d       = fill_inc[CntW-1:0];
          end
        end
        kvcr_pkg::FN_WINDOW: begin
          if (bad_cfg) begin
            status_d = kvcr_pkg::ST_BAD_CFG;
          end else begin
            if (ring_q < cfg_i.window_limit) begin
              waddr  = ring_q[AddrW-1:0];
              ring_d = ring_q + 1'b1;
            end else begin
              // wrap to first slot past the protected sink rows
              waddr  = sink_ext[AddrW-1:0];
              ring_d = sink_ext + 1'b1;
            end
            mem_req_o.we = 1'b1;
            fill_d = (fill_inc < {1'b0, cfg_i.window_limit}) ? fill_inc[CntW-1:0]
                                                             : cfg_i.window_limit;
          end
        end
        kvcr_pkg::FN_OVERWRITE: begin
          if (idx_bad) begin
            status_d = kvcr_pkg::ST_BAD_IDX;
          end else begin
            waddr        = row_index_i[AddrW-1:0];
            mem_req_o.we = 1'b1;
          end
        end
        kvcr_pkg::FN_POP: begin
          if (pop_count_i > fill_q) begin
            status_d = kvcr_pkg::ST_POP_OVR;
          end else begin
            fill_d = fill_q - pop_count_i;
          end
        end
        kvcr_pkg::FN_CLEAR: begin
          fill_d = '0;
          ring_d = '0;
        end
        kvcr_pkg::FN_READ: begin
          if (idx_bad) begin
            status_d = kvcr_pkg::ST_BAD_IDX;
          end else begin
            mem_req_o.re = 1'b1;
            rd_ok_d      = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (mem_req_o.we) begin
        slot_d = kvcr_pkg::IDX_W'(waddr);
      end
    end
    mem_req_o.waddr = waddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ring_q <= '0;
      done_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ring_q <= ring_d;
      done_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_ok_q  <= rd_ok_d;
      status_q <= status_d;
      slot_q   <= slot_d;
      rows_q   <= fill_d;
    end
  end

  assign done_o         = done_q;
  assign read_data_o    = rd_ok_q ? kvcr_pkg::DATA_W'(mem_rdata_i) : '0;
  assign status_o       = status_q;
  assign rows_filled_o  = rows_q;
  assign written_slot_o = slot_q;

endmodule

// File: hdl/kv_cache_ring_with_sinks_top.sv
// Top level of the sliding-window row cache with protected sink rows.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-----------------------------------------
//  command   | start in, busy out           | func_i, entry_data_i, row_index_i, pop_count_i
//  result    | done_o strobe, one cycle     | read_data_o, status_o, rows_filled_o,
//            |                              | written_slot_o
//  config    | APB psel/penable/pwrite      | paddr (0: window_limit, 4: sink_rows), pwdata
//
// The counters sit in flops, the row store takes at most one read or one
// write per transfer, and the result shows on the cycle after the command,
// when the store's registered read data is out.
// busy never rises, so a new command may follow on every cycle.
// Reset clears the counters and loads the register defaults; store contents
// stay undefined until written. The result side cannot stall.
module kv_cache_ring_with_sinks_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [kvcr_pkg::FUNC_W-1:0]   func_i,
  input  logic [kvcr_pkg::DATA_W-1:0]   entry_data_i,
  input  logic [kvcr_pkg::IDX_W-1:0]    row_index_i,
  input  logic [kvcr_pkg::CNT_W-1:0]    pop_count_i,
  output logic                          done_o,
  output logic [kvcr_pkg::DATA_W-1:0]   read_data_o,
  output logic [kvcr_pkg::STAT_W-1:0]   status_o,
  output logic [kvcr_pkg::CNT_W-1:0]    rows_filled_o,
  output logic [kvcr_pkg::IDX_W-1:0]    written_slot_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kvcr_pkg::APB_AW-1:0]   paddr,
  input  logic [kvcr_pkg::APB_DW-1:0]   pwdata,
  output logic [kvcr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  kvcr_pkg::cfg_t                 cfg;
  kvcr_pkg::mem_req_t             mem_req;
  logic [kvcr_pkg::ROW_BITS-1:0]  mem_rdata;
  logic                           accept;

  // commands never wait on the store, so no backpressure is needed
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  kvcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Counters and decode; issues at most one store access per transfer.
  kvcr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .func_i         (func_i),
    .entry_data_i   (entry_data_i),
    .row_index_i    (row_index_i),
    .pop_count_i    (pop_count_i),
    .cfg_i          (cfg),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .status_o       (status_o),
    .rows_filled_o  (rows_filled_o),
    .written_slot_o (written_slot_o)
  );

  // Row store. A read and a write never share a cycle, so no forwarding.
  kvcr_ram #(
    .Depth (kvcr_pkg::STORE_DEPTH),
    .Width (kvcr_pkg::ROW_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: hdl/kvcr_chk.sv
// Port-level checks for the row cache, bound to the top level.
module kvcr_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [kvcr_pkg::DATA_W-1:0]   read_data_o,
  input logic [kvcr_pkg::STAT_W-1:0]   status_o,
  input logic [kvcr_pkg::CNT_W-1:0]    rows_filled_o,
  input logic [kvcr_pkg::IDX_W-1:0]    written_slot_o
);

  a_done_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("result missing after command");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without command");

  a_fail_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != kvcr_pkg::ST_OK) |-> (written_slot_o == '0 && read_data_o == '0))
    else $error("failed command reports a slot or data");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(rows_filled_o) <= kvcr_pkg::STORE_DEPTH))
    else $error("fill count above store depth");

endmodule

bind kv_cache_ring_with_sinks_top kvcr_chk u_kvcr_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .read_data_o    (read_data_o),
  .status_o       (status_o),
  .rows_filled_o  (rows_filled_o),
  .written_slot_o (written_slot_o)
);
